[rtl/lvm_pkg.sv]
`default_nettype none

package lvm_pkg;

  // Fraction bits of the rotation rows (Q2.30).
  localparam int ROT_FRAC = 30;

  localparam int IN_TDATA_W  = 288;
  localparam int OUT_TDATA_W = 408;

  // Three 32-bit components, x in the lowest bits.
  typedef logic [2:0][31:0] vec3_t;
  // Three 64-bit components, used before normalization.
  typedef logic [2:0][63:0] wvec3_t;
  // Three rows: right, upvec, back.
  typedef vec3_t [2:0] mat3_t;
  // Translation column, 40 bits per row.
  typedef logic [2:0][39:0] shift3_t;

  localparam logic signed [39:0] SHIFT_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SHIFT_MIN = {1'b1, {39{1'b0}}};

endpackage

`default_nettype wire

[rtl/lvm_norm.sv]
`default_nettype none

module lvm_norm #(
  parameter int SIDE_W = 192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  lvm_pkg::wvec3_t     in_vec,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output lvm_pkg::vec3_t      out_vec,
  output logic [SIDE_W-1:0]   out_side
);
  import lvm_pkg::*;

  localparam int LZ_STEPS = 6;
  localparam int SQ_STEPS = 31;
  localparam int DV_STEPS = 31;
  localparam int LAT      = 2 + LZ_STEPS + 4 + SQ_STEPS + 1 + DV_STEPS + 1;

  typedef struct packed {
    logic             z;
    logic [2:0]       neg;
    logic [2:0][30:0] u;
  } sq_pay_t;

  typedef struct packed {
    logic             z;
    logic [2:0]       neg;
    logic [30:0]      r;
  } dv_pay_t;

  // Valid and sideband travel beside the arithmetic.
  logic [LAT-1:0]    vld_r;
  logic [SIDE_W-1:0] side_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_side = side_r[LAT-1];

  // Magnitudes.
  wvec3_t c1_r, g1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= in_vec;
      for (int i = 0; i < 3; i++) begin
        g1_r[i] <= in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
      end
    end
  end

  // Largest magnitude, then a leading-zero search one step per stage.
  logic [63:0] lz_m_r [0:LZ_STEPS];
  logic [6:0]  lz_s_r [0:LZ_STEPS];
  wvec3_t      lz_c_r [0:LZ_STEPS];
  logic        lz_z_r [0:LZ_STEPS];
  logic [63:0] max_nxt;

  always_comb begin
    max_nxt = g1_r[0];
    if (g1_r[1] > max_nxt) max_nxt = g1_r[1];
    if (g1_r[2] > max_nxt) max_nxt = g1_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz_m_r[0] <= max_nxt;
      lz_s_r[0] <= '0;
      lz_c_r[0] <= c1_r;
      lz_z_r[0] <= (max_nxt == 64'd0);
    end
  end

  for (genvar k = 0; k < LZ_STEPS; k++) begin : g_lz
    localparam int STEP = 32 >> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (lz_m_r[k][63 -: STEP] == '0) begin
          lz_m_r[k+1] <= lz_m_r[k] << STEP;
          lz_s_r[k+1] <= lz_s_r[k] + 7'(STEP);
        end else begin
          lz_m_r[k+1] <= lz_m_r[k];
          lz_s_r[k+1] <= lz_s_r[k];
        end
        lz_c_r[k+1] <= lz_c_r[k];
        lz_z_r[k+1] <= lz_z_r[k];
      end
    end
  end

  // Scale so the largest magnitude has exactly 30 significant bits.
  // With s leading zeros the bit length is 64 - s.
  vec3_t       v_r;
  logic        v_z_r;
  logic [6:0]  sh_amt;
  logic        sh_right;
  logic [63:0] sh_val [3];

  always_comb begin
    sh_right = (lz_s_r[LZ_STEPS] < 7'd34);
    sh_amt   = sh_right ? (7'd34 - lz_s_r[LZ_STEPS]) : (lz_s_r[LZ_STEPS] - 7'd34);
    for (int i = 0; i < 3; i++) begin
      if (sh_right) begin
        sh_val[i] = $signed(lz_c_r[LZ_STEPS][i]) >>> sh_amt;
      end else begin
        sh_val[i] = lz_c_r[LZ_STEPS][i] << sh_amt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v_r[i] <= sh_val[i][31:0];
      end
      v_z_r <= lz_z_r[LZ_STEPS];
    end
  end

  // Magnitudes and squares of the scaled components.
  sq_pay_t          u_pay_r, q_pay_r;
  logic [2:0][61:0] sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_pay_r.neg[i] <= v_r[i][31];
        u_pay_r.u[i]   <= v_r[i][31] ? 31'(32'd0 - v_r[i]) : v_r[i][30:0];
      end
      u_pay_r.z <= v_z_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 62'(u_pay_r.u[i]) * 62'(u_pay_r.u[i]);
      end
      q_pay_r <= u_pay_r;
    end
  end

  // Square root, one result bit per stage.
  logic [61:0] sq_rad_r  [0:SQ_STEPS];
  logic [33:0] sq_rem_r  [0:SQ_STEPS];
  logic [30:0] sq_root_r [0:SQ_STEPS];
  sq_pay_t     sq_pay_r  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_pay_r[0]  <= q_pay_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [33:0] tmp;
    logic [33:0] trial;
    logic        ge;
    always_comb begin
      tmp   = {sq_rem_r[k][31:0], sq_rad_r[k][61:60]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      ge    = (tmp >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= ge ? (tmp - trial) : tmp;
        sq_root_r[k+1] <= {sq_root_r[k][29:0], ge};
        sq_pay_r[k+1]  <= sq_pay_r[k];
      end
    end
  end

  // Rounded division, one quotient bit per stage. The dividend is
  // u * 2^30 + r / 2; its upper 30 bits are known to be below r.
  logic [2:0][30:0] dv_lo_r  [0:DV_STEPS];
  logic [2:0][30:0] dv_rem_r [0:DV_STEPS];
  logic [2:0][30:0] dv_q_r   [0:DV_STEPS];
  dv_pay_t          dv_pay_r [0:DV_STEPS];
  logic [60:0]      dvd      [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = {sq_pay_r[SQ_STEPS].u[i], 30'd0} + 61'(sq_root_r[SQ_STEPS][30:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_lo_r[0][i]  <= dvd[i][30:0];
        dv_rem_r[0][i] <= {1'b0, dvd[i][60:31]};
        dv_q_r[0][i]   <= '0;
      end
      dv_pay_r[0].z   <= sq_pay_r[SQ_STEPS].z;
      dv_pay_r[0].neg <= sq_pay_r[SQ_STEPS].neg;
      dv_pay_r[0].r   <= sq_root_r[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    logic [31:0] t   [3];
    logic [31:0] dif [3];
    logic [2:0]  ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]   = {dv_rem_r[k][i], dv_lo_r[k][i][30-k]};
        ge[i]  = (t[i] >= {1'b0, dv_pay_r[k].r});
        dif[i] = t[i] - {1'b0, dv_pay_r[k].r};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k+1][i] <= ge[i] ? dif[i][30:0] : t[i][30:0];
          dv_q_r[k+1][i]   <= {dv_q_r[k][i][29:0], ge[i]};
        end
        dv_lo_r[k+1]  <= dv_lo_r[k];
        dv_pay_r[k+1] <= dv_pay_r[k];
      end
    end
  end

  // Sign and zero-vector handling.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_pay_r[DV_STEPS].z) begin
          out_vec[i] <= '0;
        end else if (dv_pay_r[DV_STEPS].neg[i]) begin
          out_vec[i] <= 32'd0 - {1'b0, dv_q_r[DV_STEPS][i]};
        end else begin
          out_vec[i] <= {1'b0, dv_q_r[DV_STEPS][i]};
        end
      end
    end
  end

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> ($signed(out_vec[0]) <= 32'sd1073741824 &&
                 $signed(out_vec[0]) >= -32'sd1073741824 &&
                 $signed(out_vec[1]) <= 32'sd1073741824 &&
                 $signed(out_vec[1]) >= -32'sd1073741824 &&
                 $signed(out_vec[2]) <= 32'sd1073741824 &&
                 $signed(out_vec[2]) >= -32'sd1073741824))
    else $error("normalized component exceeds unit magnitude");

endmodule

`default_nettype wire

[rtl/lvm_cross.sv]
`default_nettype none

module lvm_cross #(
  parameter int SIDE_W = 192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  lvm_pkg::vec3_t    in_a,
  input  lvm_pkg::vec3_t    in_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output lvm_pkg::wvec3_t   out_vec,
  output logic [SIDE_W-1:0] out_side
);
  import lvm_pkg::*;

  logic [5:0][63:0]  p_r;
  logic [1:0]        vld_r;
  logic [SIDE_W-1:0] side_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  // Products first, the differences one stage later.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 64'($signed(in_a[1])) * 64'($signed(in_b[2]));
      p_r[1] <= 64'($signed(in_a[2])) * 64'($signed(in_b[1]));
      p_r[2] <= 64'($signed(in_a[2])) * 64'($signed(in_b[0]));
      p_r[3] <= 64'($signed(in_a[0])) * 64'($signed(in_b[2]));
      p_r[4] <= 64'($signed(in_a[0])) * 64'($signed(in_b[1]));
      p_r[5] <= 64'($signed(in_a[1])) * 64'($signed(in_b[0]));
      out_vec[0] <= p_r[0] - p_r[1];
      out_vec[1] <= p_r[2] - p_r[3];
      out_vec[2] <= p_r[4] - p_r[5];
      side_r[0] <= in_side;
      side_r[1] <= side_r[0];
    end
  end

  assign out_vld  = vld_r[1];
  assign out_side = side_r[1];

endmodule

`default_nettype wire

[rtl/lvm_xlate.sv]
`default_nettype none

module lvm_xlate (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  lvm_pkg::mat3_t   in_rows,
  input  lvm_pkg::vec3_t   in_ctr,
  output logic             out_vld,
  output lvm_pkg::mat3_t   out_rows,
  output lvm_pkg::shift3_t out_shift
);
  import lvm_pkg::*;

  logic [2:0][2:0][63:0] p_r;
  logic [2:0][63:0]      s_r;
  mat3_t                 rows1_r, rows2_r;
  logic [2:0]            vld_r;
  logic signed [64:0]    ns [3];
  logic signed [64:0]    t  [3];
  logic [39:0]           sat [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // Negate, round at bit 29, drop 30 fraction bits, saturate to 40 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ns[i] = (65'sd1 <<< (ROT_FRAC - 1)) - 65'($signed(s_r[i]));
      t[i]  = ns[i] >>> ROT_FRAC;
      if (t[i] > 65'(SHIFT_MAX)) begin
        sat[i] = SHIFT_MAX;
      end else if (t[i] < 65'(SHIFT_MIN)) begin
        sat[i] = SHIFT_MIN;
      end else begin
        sat[i] = t[i][39:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= 64'($signed(in_rows[i][j])) * 64'($signed(in_ctr[j]));
        end
        s_r[i]       <= p_r[i][0] + p_r[i][1] + p_r[i][2];
        out_shift[i] <= sat[i];
      end
      rows1_r  <= in_rows;
      rows2_r  <= rows1_r;
      out_rows <= rows2_r;
    end
  end

  assign out_vld = vld_r[2];

  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_shift[0] != SHIFT_MAX && out_shift[0] != SHIFT_MIN &&
                 out_shift[1] != SHIFT_MAX && out_shift[1] != SHIFT_MIN &&
                 out_shift[2] != SHIFT_MAX && out_shift[2] != SHIFT_MIN))
    else $error("translation reached saturation with unit rows");

endmodule

`default_nettype wire

[rtl/lookat_view_matrix.sv]
`default_nettype none

// Channel  | Direction | Ports                          | Contents
// ---------+-----------+--------------------------------+---------------------------------
// in_      | slave     | in_tvalid, in_tready, in_tdata | one camera setup per transaction
// out_     | master    | out_tvalid, out_tready,        | the top three rows of the view
//          |           | out_tdata                      | matrix per transaction
//
// Every transaction is independent, and one is accepted per clock when the output
// side keeps up. The path from input to output register runs through three
// normalizers in series, each with a 31-stage square root and a 31-stage divider.
// rst_n is synchronous and active low; it clears the valid bits only.
// The whole pipeline advances on one enable. It stalls only when the output register
// holds an untaken result and the last stage carries a valid item, so bubbles are
// squeezed out while the output waits.

module lookat_view_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
  // (32 bits each, Q16.16, from bit 0 up)
  input  logic [lvm_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // right_x/y/z, upvec_x/y/z, back_x/y/z (32 bits each, Q2.30), then
  // shift_x, shift_y, shift_z (40 bits each, Q24.16), from bit 0 up
  output logic [lvm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lvm_pkg::*;

  logic   pipe_en;
  logic   out_ld;
  logic   out_vld_r;
  vec3_t  eye, ctr, up;

  assign eye = in_tdata[95:0];
  assign ctr = in_tdata[191:96];
  assign up  = in_tdata[287:192];

  // Entry stage: view direction eye - center.
  logic   s0_vld_r;
  wvec3_t d_r;
  vec3_t  ctr_r, up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= 64'($signed(eye[i])) - 64'($signed(ctr[i]));
      end
      ctr_r <= ctr;
      up_r  <= up;
    end
  end

  // back = normalize(eye - center); sideband {center, up}.
  logic         n0_vld;
  vec3_t        back0;
  logic [191:0] n0_side;

  lvm_norm #(.SIDE_W(192)) u_norm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (s0_vld_r),
    .in_vec   (d_r),
    .in_side  ({ctr_r, up_r}),
    .out_vld  (n0_vld),
    .out_vec  (back0),
    .out_side (n0_side)
  );

  // up x back; sideband {center, back}.
  logic         c0_vld;
  wvec3_t       c0_vec;
  logic [191:0] c0_side;

  lvm_cross #(.SIDE_W(192)) u_cross_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (n0_vld),
    .in_a     (n0_side[95:0]),
    .in_b     (back0),
    .in_side  ({n0_side[191:96], back0}),
    .out_vld  (c0_vld),
    .out_vec  (c0_vec),
    .out_side (c0_side)
  );

  logic         n1_vld;
  vec3_t        right1;
  logic [191:0] n1_side;

  lvm_norm #(.SIDE_W(192)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (c0_vld),
    .in_vec   (c0_vec),
    .in_side  (c0_side),
    .out_vld  (n1_vld),
    .out_vec  (right1),
    .out_side (n1_side)
  );

  // back x right; sideband {center, right, back}.
  logic         c1_vld;
  wvec3_t       c1_vec;
  logic [287:0] c1_side;

  lvm_cross #(.SIDE_W(288)) u_cross_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (n1_vld),
    .in_a     (n1_side[95:0]),
    .in_b     (right1),
    .in_side  ({n1_side[191:96], right1, n1_side[95:0]}),
    .out_vld  (c1_vld),
    .out_vec  (c1_vec),
    .out_side (c1_side)
  );

  logic         n2_vld;
  vec3_t        upvec2;
  logic [287:0] n2_side;

  lvm_norm #(.SIDE_W(288)) u_norm_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (c1_vld),
    .in_vec   (c1_vec),
    .in_side  (c1_side),
    .out_vld  (n2_vld),
    .out_vec  (upvec2),
    .out_side (n2_side)
  );

  // Translation column.
  mat3_t   rows2;
  logic    x_vld;
  mat3_t   x_rows;
  shift3_t x_shift;

  assign rows2[0] = n2_side[191:96];
  assign rows2[1] = upvec2;
  assign rows2[2] = n2_side[95:0];

  lvm_xlate u_xlate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_vld    (n2_vld),
    .in_rows   (rows2),
    .in_ctr    (n2_side[287:192]),
    .out_vld   (x_vld),
    .out_rows  (x_rows),
    .out_shift (x_shift)
  );

  // Output register. A bubble in the last stage may be dropped while a
  // result waits, so the pipeline keeps filling behind it.
  assign out_ld    = !out_vld_r || out_tready;
  assign pipe_en   = out_ld || !x_vld;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_tdata <= {x_shift, x_rows};
    end
  end

  assign out_tvalid = out_vld_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && x_vld) |-> !pipe_en)
    else $error("finished item would be overwritten while the output stalls");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("waiting output transaction changed before it was taken");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
